### rtl/core/dtbp_pkg.sv
// ----------------------------------------------------------------------------
// dtbp_pkg
// Shared types and constants of the dual touch button press classifier.
// ----------------------------------------------------------------------------
package dtbp_pkg;

  localparam int unsigned TimeBitsDef = 32;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPressThr   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgReleaseThr = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgDebounce   = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgLongPress  = 4'd3;

  // configuration reset values
  localparam logic [7:0]  PressThrRst   = 8'd70;
  localparam logic [7:0]  ReleaseThrRst = 8'd50;
  localparam logic [15:0] DebounceRst   = 16'd40;
  localparam logic [15:0] LongPressRst  = 16'd800;

  // button event codes
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvShort = 2'd1;
  localparam logic [1:0] EvLong  = 2'd2;

  typedef struct packed {
    logic [7:0]  level_a;
    logic [7:0]  level_b;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] event_a;
    logic [1:0] event_b;
    logic       reset_request;
  } out_t;

  typedef struct packed {
    logic [7:0]  press_threshold;
    logic [7:0]  release_threshold;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

endpackage

### rtl/core/dual_touch_button_press_classifier.sv
// ----------------------------------------------------------------------------
// dual_touch_button_press_classifier
// Debounces two touch levels and classifies short and long presses.
// ----------------------------------------------------------------------------
// path: the input beat passes the input register, then the result register;
//   the button state updates as the beat moves between them
// throughput: one beat per cycle, ready stays high while the result is taken
// reset: all button state cleared, registers back to 70 / 50 / 40 / 800
module dual_touch_button_press_classifier #(
  parameter int unsigned TIME_BITS = dtbp_pkg::TimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dtbp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dtbp_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtbp_pkg::CfgDataW-1:0] cfg_data_i
);
  import dtbp_pkg::*;

  cfg_t                 cfg;
  logic                 in_valid_q;
  in_t                  in_data_q;
  logic                 out_valid_q;
  out_t                 out_data_q, out_data_d;
  logic                 advance;
  logic [TIME_BITS-1:0] now;
  logic                 long_a, long_b;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign now        = TIME_BITS'(in_data_q.now_ms);

  dtbp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtbp_button #(.TIME_BITS(TIME_BITS)) u_button_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (in_data_q.level_a),
    .now_i   (now),
    .cfg_i   (cfg),
    .event_o (out_data_d.event_a),
    .long_o  (long_a)
  );

  dtbp_button #(.TIME_BITS(TIME_BITS)) u_button_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (in_data_q.level_b),
    .now_i   (now),
    .cfg_i   (cfg),
    .event_o (out_data_d.event_b),
    .long_o  (long_b)
  );

  assign out_data_d.reset_request = long_a && long_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/dtbp_cfg.sv
// ----------------------------------------------------------------------------
// dtbp_cfg
// Configuration register file: thresholds and timing limits.
// ----------------------------------------------------------------------------
module dtbp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtbp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtbp_pkg::CfgDataW-1:0] cfg_data_i,
  output dtbp_pkg::cfg_t                cfg_o
);
  import dtbp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPressThr:   cfg_d.press_threshold   = cfg_data_i[7:0];
        CfgReleaseThr: cfg_d.release_threshold = cfg_data_i[7:0];
        CfgDebounce:   cfg_d.debounce_ms       = cfg_data_i;
        CfgLongPress:  cfg_d.long_press_ms     = cfg_data_i;
        default:       cfg_d = cfg_q;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_threshold   <= PressThrRst;
      cfg_q.release_threshold <= ReleaseThrRst;
      cfg_q.debounce_ms       <= DebounceRst;
      cfg_q.long_press_ms     <= LongPressRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/dtbp_button.sv
// ----------------------------------------------------------------------------
// dtbp_button
// One button: debounce stage followed by the short/long press stage.
// ----------------------------------------------------------------------------
module dtbp_button #(
  parameter int unsigned TIME_BITS = dtbp_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           level_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  dtbp_pkg::cfg_t       cfg_i,
  output logic [1:0]           event_o,
  output logic                 long_o
);
  import dtbp_pkg::*;

  logic                 touched_q, touched_d;
  logic                 pressed_q, pressed_d;
  logic                 active_q, active_d;
  logic                 long_q, long_d;
  logic [TIME_BITS-1:0] touch_start_q, touch_start_d;
  logic [TIME_BITS-1:0] hold_start_q, hold_start_d;
  logic [TIME_BITS-1:0] touch_elapsed, hold_base, hold_elapsed;
  logic                 below, above;
  logic [1:0]           event_d;

  assign below         = level_i < cfg_i.press_threshold;
  assign above         = level_i > cfg_i.release_threshold;
  assign touch_elapsed = now_i - touch_start_q;
  // a fresh hold starts now, so its elapsed time is zero
  assign hold_base     = active_q ? hold_start_q : now_i;
  assign hold_elapsed  = now_i - hold_base;

  always_comb begin
    touched_d     = touched_q;
    pressed_d     = pressed_q;
    active_d      = active_q;
    long_d        = long_q;
    touch_start_d = touch_start_q;
    hold_start_d  = hold_start_q;
    event_d       = EvNone;

    // debounce
    if (!touched_q && below) begin
      touched_d     = 1'b1;
      touch_start_d = now_i;
    end else if (touched_q && below) begin
      if (touch_elapsed >= TIME_BITS'(cfg_i.debounce_ms)) begin
        pressed_d = 1'b1;
      end
    end else if (above) begin
      touched_d = 1'b0;
      pressed_d = 1'b0;
    end

    // press classification
    if (pressed_d) begin
      if (!active_q) begin
        active_d     = 1'b1;
        hold_start_d = now_i;
      end
      if (hold_elapsed > TIME_BITS'(cfg_i.long_press_ms) && !long_q) begin
        long_d  = 1'b1;
        event_d = EvLong;
      end
    end else if (active_q) begin
      if (long_q) begin
        long_d = 1'b0;
      end else begin
        event_d = EvShort;
      end
      active_d = 1'b0;
    end
  end

  assign event_o = event_d;
  assign long_o  = long_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q     <= 1'b0;
      pressed_q     <= 1'b0;
      active_q      <= 1'b0;
      long_q        <= 1'b0;
      touch_start_q <= '0;
      hold_start_q  <= '0;
    end else if (step_i) begin
      touched_q     <= touched_d;
      pressed_q     <= pressed_d;
      active_q      <= active_d;
      long_q        <= long_d;
      touch_start_q <= touch_start_d;
      hold_start_q  <= hold_start_d;
    end
  end

endmodule

### rtl/core/dtbp_checker.sv
// ----------------------------------------------------------------------------
// dtbp_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module dtbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input dtbp_pkg::out_t out_data_o
);
  import dtbp_pkg::*;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // both long presses held: no button can be reporting a release
  a_reset_no_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reset_request) |->
      (out_data_o.event_a != EvShort && out_data_o.event_b != EvShort))
    else $error("short press reported with reset request");

endmodule

bind dual_touch_button_press_classifier dtbp_checker u_dtbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual touch button press classifier. A short
// scripted sequence hits the threshold, timing and wrap corners. Randomized
// press and release sequences follow under several register settings. Every
// result beat is compared against a behavioral model of both buttons or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_top;
  import dtbp_pkg::*;

  typedef struct {
    bit          touched;
    logic [31:0] touch_start;
    bit          pressed;
    bit          active;
    logic [31:0] hold_start;
    bit          long_fired;
  } key_state_t;

  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] val;
    in_t                 smp;
    bit                  fixed;
    out_t                want;
  } script_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // model of the block
  key_state_t  keys [2];
  logic [7:0]  thr_press;
  logic [7:0]  thr_release;
  logic [15:0] debounce_len;
  logic [15:0] long_len;

  out_t        press_results_q [$];
  script_row_t script [$];
  bit          steady = 1'b0;
  int unsigned fail_count  = 0;
  int unsigned n_beats     = 0;
  int unsigned n_short     = 0;
  int unsigned n_long      = 0;
  int unsigned n_reset_req = 0;

  dual_touch_button_press_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_model();
    thr_press    = PressThrRst;
    thr_release  = ReleaseThrRst;
    debounce_len = DebounceRst;
    long_len     = LongPressRst;
    for (int k = 0; k < 2; k++) begin
      keys[k] = '{1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0};
    end
  endfunction

  // debounce stage then press stage of one button
  function automatic logic [1:0] advance_key(int k, logic [7:0] lvl, logic [31:0] stamp);
    logic [1:0]  ev;
    logic [31:0] elapsed;
    ev = EvNone;
    if (!keys[k].touched && lvl < thr_press) begin
      keys[k].touch_start = stamp;
      keys[k].touched     = 1'b1;
    end else if (keys[k].touched && lvl < thr_press) begin
      elapsed = stamp - keys[k].touch_start;
      if (elapsed >= 32'(debounce_len)) keys[k].pressed = 1'b1;
    end else if (lvl > thr_release) begin
      keys[k].touched = 1'b0;
      keys[k].pressed = 1'b0;
    end
    if (keys[k].pressed) begin
      if (!keys[k].active) begin
        keys[k].active     = 1'b1;
        keys[k].hold_start = stamp;
      end
      elapsed = stamp - keys[k].hold_start;
      if (elapsed > 32'(long_len) && !keys[k].long_fired) begin
        keys[k].long_fired = 1'b1;
        ev = EvLong;
      end
    end else if (keys[k].active) begin
      // release after a long press reports nothing
      if (keys[k].long_fired) keys[k].long_fired = 1'b0;
      else ev = EvShort;
      keys[k].active = 1'b0;
    end
    return ev;
  endfunction

  function automatic out_t classify(in_t s);
    out_t r;
    r.event_a       = advance_key(0, s.level_a, s.now_ms);
    r.event_b       = advance_key(1, s.level_b, s.now_ms);
    r.reset_request = keys[0].long_fired && keys[1].long_fired;
    return r;
  endfunction

  function automatic script_row_t beat_row(logic [7:0] a, logic [7:0] b, logic [31:0] stamp);
    script_row_t r;
    r = '{1'b0, '0, '0, '{a, b, stamp}, 1'b0, '0};
    return r;
  endfunction

  function automatic script_row_t fixed_row(logic [7:0] a, logic [7:0] b, logic [31:0] stamp,
                                            out_t want);
    script_row_t r;
    r = '{1'b0, '0, '0, '{a, b, stamp}, 1'b1, want};
    return r;
  endfunction

  function automatic script_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    script_row_t r;
    r = '{1'b1, idx, val, '0, 1'b0, '0};
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // leaves valid high so back-to-back writes never drop it within a step
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgPressThr:   thr_press    = val[7:0];
      CfgReleaseThr: thr_release  = val[7:0];
      CfgDebounce:   debounce_len = val;
      CfgLongPress:  long_len     = val;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (press_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_sample(in_t s, bit fixed, out_t want);
    out_t predicted;
    while (!steady && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = classify(s);
    press_results_q.push_back(fixed ? want : predicted);
  endtask

  // result side: random stalls except during the steady phase
  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 18);

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_beats++;
      if (out_data_o.event_a == EvShort || out_data_o.event_b == EvShort) n_short++;
      if (out_data_o.event_a == EvLong || out_data_o.event_b == EvLong) n_long++;
      if (out_data_o.reset_request) n_reset_req++;
      if (press_results_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(out_data_o), 32'd0);
      end else begin
        want = press_results_q.pop_front();
        if (out_data_o.event_a !== want.event_a)
          report_mismatch("event_a", 32'(out_data_o.event_a), 32'(want.event_a));
        if (out_data_o.event_b !== want.event_b)
          report_mismatch("event_b", 32'(out_data_o.event_b), 32'(want.event_b));
        if (out_data_o.reset_request !== want.reset_request)
          report_mismatch("reset_request", 32'(out_data_o.reset_request),
                          32'(want.reset_request));
      end
    end
  end

  initial begin
    out_t        idle_out;
    cfg_t        c;
    in_t         s;
    bit          down [2];
    logic [7:0]  lvl [2];
    logic [31:0] stamp;
    int unsigned span;
    int unsigned r;

    clear_model();
    idle_out = '{EvNone, EvNone, 1'b0};

    script.push_back(fixed_row(8'd255, 8'd255, 32'd0, idle_out));
    script.push_back(beat_row(8'd0, 8'd0, 32'd100));
    script.push_back(beat_row(8'd0, 8'd0, 32'd140));    // debounce met exactly
    script.push_back(beat_row(8'd0, 8'd0, 32'd940));    // hold equals long time
    script.push_back(beat_row(8'd0, 8'd0, 32'd941));    // both long, reset request
    script.push_back(beat_row(8'd0, 8'd0, 32'd2000));
    script.push_back(beat_row(8'd255, 8'd0, 32'd2001));
    script.push_back(beat_row(8'd255, 8'd255, 32'd2002));
    script.push_back(beat_row(8'd0, 8'd255, 32'd3000));
    script.push_back(beat_row(8'd0, 8'd255, 32'd3040));
    script.push_back(beat_row(8'd255, 8'd255, 32'd3100)); // short press
    script.push_back(beat_row(8'd255, 8'd0, 32'hFFFF_FFF0));
    script.push_back(beat_row(8'd255, 8'd0, 32'h0000_0018)); // debounce across wrap
    script.push_back(beat_row(8'd255, 8'd0, 32'h0000_0339));
    script.push_back(beat_row(8'd255, 8'd255, 32'h0000_0400));
    // every level sits between the thresholds, state must hold
    script.push_back(reg_row(CfgPressThr, 16'hFF00));
    script.push_back(reg_row(CfgReleaseThr, 16'h00FF));
    script.push_back(fixed_row(8'd0, 8'd255, 32'h0000_1000, idle_out));
    // overlapping thresholds, zero timing
    script.push_back(reg_row(CfgPressThr, 16'h00FF));
    script.push_back(reg_row(CfgReleaseThr, 16'h0000));
    script.push_back(reg_row(CfgDebounce, 16'h0000));
    script.push_back(reg_row(CfgLongPress, 16'h0000));
    script.push_back(beat_row(8'd100, 8'd128, 32'd5));
    script.push_back(beat_row(8'd254, 8'd254, 32'd5));
    script.push_back(beat_row(8'd254, 8'd0, 32'd6));
    script.push_back(beat_row(8'd255, 8'd255, 32'd7));
    script.push_back(reg_row(CfgDebounce, 16'hFFFF));
    script.push_back(reg_row(CfgLongPress, 16'hFFFF));
    script.push_back(reg_row(4'hF, 16'h1234));       // unknown index, ignored
    script.push_back(beat_row(8'd0, 8'd0, 32'd8));
    script.push_back(beat_row(8'd0, 8'd0, 32'd65543));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        wait_drain();
        write_reg(script[i].idx, script[i].val);
        cfg_valid_i <= 1'b0;
      end else begin
        send_sample(script[i].smp, script[i].fixed, script[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      wait_drain();
      c.press_threshold   = 8'($urandom_range(1, 255));
      c.release_threshold = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, c.press_threshold - 1));
      c.debounce_ms       = 16'($urandom_range(0, 120));
      c.long_press_ms     = 16'($urandom_range(0, 1500));
      case (p)
        0: c = '{PressThrRst, ReleaseThrRst, DebounceRst, LongPressRst};
        1: begin
          c.debounce_ms   = '0;
          c.long_press_ms = '0;
        end
        2: begin
          c.debounce_ms   = 16'hFFFF;
          c.long_press_ms = 16'hFFFF;
        end
        7: begin
          c.press_threshold   = 8'hFF;
          c.release_threshold = 8'h00;
        end
        default: ;
      endcase
      // upper byte of the 8-bit registers carries junk
      write_reg(CfgPressThr, {8'($urandom), c.press_threshold});
      write_reg(CfgReleaseThr, {8'($urandom), c.release_threshold});
      write_reg(CfgDebounce, c.debounce_ms);
      write_reg(CfgLongPress, c.long_press_ms);
      write_reg(4'($urandom_range(4, 15)), 16'($urandom));
      cfg_valid_i <= 1'b0;

      steady = (p == 3);
      stamp  = (p % 2 == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 5000);
      span   = ((long_len > debounce_len) ? long_len : debounce_len) + 4;
      down   = '{1'b0, 1'b0};
      for (int i = 0; i < 50; i++) begin
        if (p == 5 && i == 25) wait_drain();
        for (int k = 0; k < 2; k++) begin
          if ($urandom_range(99) < 20) down[k] = !down[k];
          if ($urandom_range(99) < 10)
            lvl[k] = 8'($urandom_range(0, 255));
          else if (down[k])
            lvl[k] = (thr_press == 0) ? 8'd0 : 8'($urandom_range(0, thr_press - 1));
          else
            lvl[k] = (thr_release == 8'hFF) ? 8'hFF : 8'($urandom_range(thr_release + 1, 255));
        end
        r = $urandom_range(99);
        if (r < 60) stamp = stamp + $urandom_range(0, span / 4);
        else if (r < 90) stamp = stamp + $urandom_range(0, span + span / 2);
        else stamp = $urandom;
        s = '{lvl[0], lvl[1], stamp};
        send_sample(s, 1'b0, idle_out);
      end
      steady = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (press_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d result beats: default, zero, maximum and random register settings",
             n_beats);
    $display("beats with a short press %0d, with a long press %0d, with reset request %0d",
             n_short, n_long, n_reset_req);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d beats pending", press_results_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/core/dtbp_pkg.sv
rtl/core/dtbp_cfg.sv
rtl/core/dtbp_button.sv
rtl/core/dual_touch_button_press_classifier.sv
rtl/core/dtbp_checker.sv
verif/tb_top.sv
